/* design/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB/HSV colour converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    // field widths
    localparam int TAG_W = 16;
    localparam int HUE_W = 9;
    localparam int CH_W  = 8;

    // fixed-point full scales
    localparam int HUE_FULL = 359;
    localparam int CH_FULL  = 255;

    // sector search works on t = 6 * hue
    localparam int T_W = 12;
    // hue numerator term, below 6 * (max - min)
    localparam int N_W = 11;

    // pipelined divider geometry
    localparam int NUM_W = 25;
    localparam int DEN_W = 17;
    localparam int Q_W   = 9;
    localparam int CMP_W = DEN_W + Q_W;

    // channel mix divisor and its rounding half
    localparam int MIX_DEN  = CH_FULL * HUE_FULL;
    localparam int MIX_HALF = MIX_DEN / 2;

    // lanes through the back end
    localparam int LANES = 3;

    // word queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        DIR_RGB_TO_HSV = 1'b0,
        DIR_HSV_TO_RGB = 1'b1
    } dir_t;

    typedef struct packed
    {
        logic [TAG_W-1:0] position_tag;
        logic [HUE_W-1:0] in_first;
        logic [CH_W-1:0]  in_second;
        logic [CH_W-1:0]  in_third;
    } item_t;

    typedef struct packed
    {
        logic [TAG_W-1:0] out_tag;
        logic [HUE_W-1:0] out_first;
        logic [CH_W-1:0]  out_second;
        logic [CH_W-1:0]  out_third;
    } result_t;

    // classified word held in the queue
    typedef struct packed
    {
        logic [TAG_W-1:0] tag;
        dir_t             dir;
        // hsv to rgb: channel fractions, saturation, value
        logic [HUE_W-1:0] frac_r;
        logic [HUE_W-1:0] frac_g;
        logic [HUE_W-1:0] frac_b;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        // rgb to hsv: max, spread, hue term, grey flag
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  spread;
        logic [N_W-1:0]   hterm;
        logic             grey;
    } entry_t;

endpackage

`default_nettype wire

/* design/rgb_hsv_color_converter.sv */
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter
// RGB/HSV colour converter with a pass-through position tag.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one result word per word, in order:
// the queue hands the word on in the next cycle, two register stages form
// numerators and divisors, and nine pipelined divider stages give one
// quotient bit each. The result is shown on result for the single cycle in
// which done is high and must be taken then. busy rises only when the
// two-word queue is full, which a steady one-word-per-cycle flow does not
// reach. direction (reset 1, HSV to RGB) is to be written by the user with
// cfg_we/cfg_data only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_hsv_color_converter
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_data,
    input  wire logic           start,
    input  wire rhc_pkg::item_t item,
    output logic                busy,
    output logic                done,
    output rhc_pkg::result_t    result
);

    logic            direction_reg;
    logic            push;
    logic            pop;
    rhc_pkg::entry_t front_word;
    rhc_pkg::entry_t head_word;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= rhc_pkg::DIR_HSV_TO_RGB;
        else if (cfg_we)
            direction_reg <= cfg_data;
    end

    assign push = start && !busy;

    // classify
    rhc_front u_front
    (
        .direction (direction_reg),
        .item      (item),
        .entry     (front_word)
    );

    // decouple
    rhc_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_word),
        .full  (busy),
        .pop   (pop),
        .rdata (head_word)
    );

    // compute
    rhc_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pop    (pop),
        .entry  (head_word),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

/* design/rhc_div.sv */
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per stage, Q_W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div
(
    input  wire logic                     clk,
    input  wire logic [rhc_pkg::NUM_W-1:0] num,
    input  wire logic [rhc_pkg::DEN_W-1:0] den,
    output logic      [rhc_pkg::Q_W-1:0]   quot
);

    logic [rhc_pkg::NUM_W-1:0] rem_reg  [rhc_pkg::Q_W];
    logic [rhc_pkg::DEN_W-1:0] den_reg  [rhc_pkg::Q_W];
    logic [rhc_pkg::Q_W-1:0]   quot_reg [rhc_pkg::Q_W];

    for (genvar k = 0; k < rhc_pkg::Q_W; k++)
    begin : g_stage
        localparam int SH = rhc_pkg::Q_W - 1 - k;

        logic [rhc_pkg::NUM_W-1:0] rem_in;
        logic [rhc_pkg::DEN_W-1:0] den_in;
        logic [rhc_pkg::Q_W-1:0]   quot_in;
        logic [rhc_pkg::CMP_W-1:0] den_sh;
        logic                      ge;
        logic [rhc_pkg::NUM_W-1:0] rem_next;
        logic [rhc_pkg::Q_W-1:0]   quot_next;

        // stage inputs
        if (k == 0)
        begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb
        begin
            den_sh    = rhc_pkg::CMP_W'(den_in) << SH;
            ge        = rhc_pkg::CMP_W'(rem_in) >= den_sh;
            rem_next  = ge ? rem_in - rhc_pkg::NUM_W'(den_sh) : rem_in;
            quot_next = quot_in;
            quot_next[SH] = ge;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_in;
            quot_reg[k] <= quot_next;
        end
    end

    assign quot = quot_reg[rhc_pkg::Q_W-1];

endmodule

`default_nettype wire

/* design/rhc_front.sv */
// ----------------------------------------------------------------------------
// rhc_front
// Front end: saturates inputs and classifies each word (hue sector or
// dominant channel) ahead of the arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front
(
    input  wire logic           direction,
    input  wire rhc_pkg::item_t item,
    output rhc_pkg::entry_t     entry
);

    localparam int HF = rhc_pkg::HUE_FULL;

    logic [rhc_pkg::HUE_W-1:0] hue;
    logic [rhc_pkg::T_W-1:0]   t;
    logic [rhc_pkg::HUE_W-1:0] fr;
    logic [rhc_pkg::HUE_W-1:0] fg;
    logic [rhc_pkg::HUE_W-1:0] fb;
    logic [rhc_pkg::CH_W-1:0]  red;
    logic [rhc_pkg::CH_W-1:0]  grn;
    logic [rhc_pkg::CH_W-1:0]  blu;
    logic [rhc_pkg::CH_W-1:0]  mx;
    logic [rhc_pkg::CH_W-1:0]  mn;
    logic [rhc_pkg::CH_W-1:0]  spread;
    logic signed [rhc_pkg::T_W:0] n;

    // hsv: sector from t = 6 * hue
    always_comb
    begin
        hue = (item.in_first > rhc_pkg::HUE_W'(HF)) ? rhc_pkg::HUE_W'(HF) : item.in_first;
        t   = rhc_pkg::T_W'(hue) * rhc_pkg::T_W'(6);
        fr  = '0;
        fg  = '0;
        fb  = '0;
        if (t > rhc_pkg::T_W'(HF) && t <= rhc_pkg::T_W'(2 * HF))
        begin
            fg = rhc_pkg::HUE_W'(HF);
            fr = rhc_pkg::HUE_W'(rhc_pkg::T_W'(2 * HF) - t);
        end
        else if (t > rhc_pkg::T_W'(2 * HF) && t <= rhc_pkg::T_W'(3 * HF))
        begin
            fg = rhc_pkg::HUE_W'(HF);
            fb = rhc_pkg::HUE_W'(t - rhc_pkg::T_W'(2 * HF));
        end
        else if (t > rhc_pkg::T_W'(3 * HF) && t <= rhc_pkg::T_W'(4 * HF))
        begin
            fb = rhc_pkg::HUE_W'(HF);
            fg = rhc_pkg::HUE_W'(rhc_pkg::T_W'(4 * HF) - t);
        end
        else if (t > rhc_pkg::T_W'(4 * HF) && t <= rhc_pkg::T_W'(5 * HF))
        begin
            fb = rhc_pkg::HUE_W'(HF);
            fr = rhc_pkg::HUE_W'(t - rhc_pkg::T_W'(4 * HF));
        end
        else if (t > rhc_pkg::T_W'(5 * HF))
        begin
            fr = rhc_pkg::HUE_W'(HF);
            fb = rhc_pkg::HUE_W'(rhc_pkg::T_W'(6 * HF) - t);
        end
        else
        begin
            fr = rhc_pkg::HUE_W'(HF);
            fg = rhc_pkg::HUE_W'(t);
        end
    end

    // rgb: max, min and dominant channel
    always_comb
    begin
        red = (item.in_first > rhc_pkg::HUE_W'(rhc_pkg::CH_FULL)) ?
              rhc_pkg::CH_W'(rhc_pkg::CH_FULL) : item.in_first[rhc_pkg::CH_W-1:0];
        grn = item.in_second;
        blu = item.in_third;
        mx  = red;
        mn  = red;
        if (grn > mx) mx = grn;
        if (grn < mn) mn = grn;
        if (blu > mx) mx = blu;
        if (blu < mn) mn = blu;
        spread = mx - mn;
        if (red == mx)
            n = $signed({1'b0, rhc_pkg::T_W'(grn)}) - $signed({1'b0, rhc_pkg::T_W'(blu)});
        else if (grn == mx)
            n = $signed({1'b0, rhc_pkg::T_W'(spread) * rhc_pkg::T_W'(2)})
                + $signed({1'b0, rhc_pkg::T_W'(blu)}) - $signed({1'b0, rhc_pkg::T_W'(red)});
        else
            n = $signed({1'b0, rhc_pkg::T_W'(spread) * rhc_pkg::T_W'(4)})
                + $signed({1'b0, rhc_pkg::T_W'(red)}) - $signed({1'b0, rhc_pkg::T_W'(grn)});
        if (n < 0)
            n = n + $signed({1'b0, rhc_pkg::T_W'(spread) * rhc_pkg::T_W'(6)});
    end

    // assemble the queue word
    always_comb
    begin
        entry.tag    = item.position_tag;
        entry.dir    = rhc_pkg::dir_t'(direction);
        entry.frac_r = fr;
        entry.frac_g = fg;
        entry.frac_b = fb;
        entry.sat    = item.in_second;
        entry.val    = item.in_third;
        entry.mx     = mx;
        entry.spread = spread;
        entry.hterm  = n[rhc_pkg::N_W-1:0];
        entry.grey   = (spread == '0);
    end

endmodule

`default_nettype wire

/* design/rhc_queue.sv */
// ----------------------------------------------------------------------------
// rhc_queue
// Short word queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rhc_pkg::entry_t wdata,
    output logic                 full,
    output logic                 pop,
    output rhc_pkg::entry_t      rdata
);

    rhc_pkg::entry_t             mem_reg [rhc_pkg::QUEUE_DEPTH];
    logic [rhc_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rhc_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rhc_pkg::QCNT_W-1:0]  count_reg, count_next;

    // back end drains a word every cycle one is present
    assign pop   = (count_reg != '0);
    assign full  = (count_reg == rhc_pkg::QCNT_W'(rhc_pkg::QUEUE_DEPTH));
    assign rdata = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + rhc_pkg::QCNT_W'(push) - rhc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // with a drain every cycle the queue never holds more than one word
    a_one_deep: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rhc_pkg::QCNT_W'(1))
        else $error("queue holds more than one word");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> pop)
        else $error("pushed word not drained next cycle");

endmodule

`default_nettype wire

/* design/rhc_back.sv */
// ----------------------------------------------------------------------------
// rhc_back
// Back end: forms numerators and divisors per lane, then runs three
// pipelined dividers; tag and valid travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop,
    input  wire rhc_pkg::entry_t entry,
    output logic                 done,
    output rhc_pkg::result_t     result
);

    localparam int L = rhc_pkg::LANES;

    logic                      s1_valid_reg;
    rhc_pkg::dir_t             s1_dir_reg;
    logic [rhc_pkg::TAG_W-1:0] s1_tag_reg;
    logic [rhc_pkg::CH_W-1:0]  s1_val_reg;
    logic [rhc_pkg::NUM_W-1:0] s1_num_reg [L];
    logic [rhc_pkg::DEN_W-1:0] s1_den_reg [L];
    logic [rhc_pkg::NUM_W-1:0] s1_num_next [L];
    logic [rhc_pkg::DEN_W-1:0] s1_den_next [L];

    logic                      s2_valid_reg;
    logic [rhc_pkg::TAG_W-1:0] s2_tag_reg;
    logic [rhc_pkg::NUM_W-1:0] s2_num_reg [L];
    logic [rhc_pkg::DEN_W-1:0] s2_den_reg [L];
    logic [rhc_pkg::NUM_W-1:0] s2_num_next [L];
    logic [rhc_pkg::DEN_W-1:0] s2_den_next [L];

    logic                      vld_reg [rhc_pkg::Q_W];
    logic [rhc_pkg::TAG_W-1:0] tag_reg [rhc_pkg::Q_W];
    logic [rhc_pkg::Q_W-1:0]   quot [L];
    logic [rhc_pkg::HUE_W-1:0] frac [L];
    logic [rhc_pkg::NUM_W-1:0] mix;

    assign frac[0] = entry.frac_r;
    assign frac[1] = entry.frac_g;
    assign frac[2] = entry.frac_b;

    // stage 1: saturation mix, or hue, saturation and value numerators
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            s1_num_next[i] = '0;
            s1_den_next[i] = rhc_pkg::DEN_W'(1);
        end
        mix = '0;
        if (entry.dir == rhc_pkg::DIR_HSV_TO_RGB)
        begin
            for (int i = 0; i < L; i++)
            begin
                mix = rhc_pkg::NUM_W'(entry.sat) * rhc_pkg::NUM_W'(frac[i])
                    + rhc_pkg::NUM_W'(rhc_pkg::CH_W'(rhc_pkg::CH_FULL) - entry.sat)
                    * rhc_pkg::NUM_W'(rhc_pkg::HUE_FULL);
                s1_num_next[i] = mix;
            end
        end
        else
        begin
            if (!entry.grey)
            begin
                s1_num_next[0] = rhc_pkg::NUM_W'(entry.hterm) * rhc_pkg::NUM_W'(rhc_pkg::HUE_FULL)
                               + rhc_pkg::NUM_W'(entry.spread) * rhc_pkg::NUM_W'(3);
                s1_den_next[0] = rhc_pkg::DEN_W'(entry.spread) * rhc_pkg::DEN_W'(6);
                s1_num_next[1] = rhc_pkg::NUM_W'(entry.spread) * rhc_pkg::NUM_W'(rhc_pkg::CH_FULL)
                               + rhc_pkg::NUM_W'(entry.mx >> 1);
                s1_den_next[1] = rhc_pkg::DEN_W'(entry.mx);
            end
            s1_num_next[2] = rhc_pkg::NUM_W'(entry.mx);
        end
    end

    // stage 2: for HSV to RGB scale by value and add the rounding half, else pass through
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            if (s1_dir_reg == rhc_pkg::DIR_HSV_TO_RGB)
            begin
                s2_num_next[i] = rhc_pkg::NUM_W'(s1_val_reg) * s1_num_reg[i]
                               + rhc_pkg::NUM_W'(rhc_pkg::MIX_HALF);
                s2_den_next[i] = rhc_pkg::DEN_W'(rhc_pkg::MIX_DEN);
            end
            else
            begin
                s2_num_next[i] = s1_num_reg[i];
                s2_den_next[i] = s1_den_reg[i];
            end
        end
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < rhc_pkg::Q_W; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            vld_reg[0]   <= s2_valid_reg;
            for (int i = 1; i < rhc_pkg::Q_W; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        s1_dir_reg <= entry.dir;
        s1_tag_reg <= entry.tag;
        s1_val_reg <= entry.val;
        s2_tag_reg <= s1_tag_reg;
        for (int i = 0; i < L; i++)
        begin
            s1_num_reg[i] <= s1_num_next[i];
            s1_den_reg[i] <= s1_den_next[i];
            s2_num_reg[i] <= s2_num_next[i];
            s2_den_reg[i] <= s2_den_next[i];
        end
        tag_reg[0] <= s2_tag_reg;
        for (int i = 1; i < rhc_pkg::Q_W; i++)
            tag_reg[i] <= tag_reg[i-1];
    end

    // one divider per lane
    for (genvar g = 0; g < L; g++)
    begin : g_lane
        rhc_div u_div
        (
            .clk  (clk),
            .num  (s2_num_reg[g]),
            .den  (s2_den_reg[g]),
            .quot (quot[g])
        );
    end

    // result word
    assign done              = vld_reg[rhc_pkg::Q_W-1];
    assign result.out_tag    = tag_reg[rhc_pkg::Q_W-1];
    assign result.out_first  = quot[0];
    assign result.out_second = quot[1][rhc_pkg::CH_W-1:0];
    assign result.out_third  = quot[2][rhc_pkg::CH_W-1:0];

    // second and third lane quotients (green and blue, or saturation and value) stay within eight bits
    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!quot[1][rhc_pkg::CH_W] && !quot[2][rhc_pkg::CH_W]))
        else $error("channel quotient above full scale");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quot[0] <= rhc_pkg::Q_W'(rhc_pkg::HUE_FULL)))
        else $error("hue quotient above full circle");

endmodule

`default_nettype wire
